[rtl/isp_pkg.sv]
// ---------------------------------------------------------------------------
// isp_pkg
// shared types and constants for the interrupted sinusoidal projection
// ---------------------------------------------------------------------------
package isp_pkg;

  localparam int FRAC_BITS = 28;
  localparam int SHIFT_IN  = 60 - FRAC_BITS;
  localparam int LIM_SH    = FRAC_BITS + 2;
  localparam int NSTEP     = 11;

  localparam logic CMD_FWD = 1'b0;
  localparam logic CMD_INV = 1'b1;

  localparam logic [1:0] LOBE_W = 2'd0;
  localparam logic [1:0] LOBE_C = 2'd1;
  localparam logic [1:0] LOBE_E = 2'd2;

  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] PI_60   = PI_Q62 / 64'd60;
  localparam logic [63:0] PI_Q60  = (PI_Q62 + 64'd2) >> 2;
  localparam logic [63:0] HALF_PI = (PI_Q62 + 64'd4) >> 3;
  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] COS_EPS = 64'd115292150;

  localparam logic [63:0] KPI_6  = (PI_60 * 64'd6 + 64'd2) >> 2;
  localparam logic [63:0] KPI_7  = (PI_60 * 64'd7 + 64'd2) >> 2;
  localparam logic [63:0] KPI_13 = (PI_60 * 64'd13 + 64'd2) >> 2;
  localparam logic [63:0] KPI_20 = (PI_60 * 64'd20 + 64'd2) >> 2;
  localparam logic [63:0] KPI_27 = (PI_60 * 64'd27 + 64'd2) >> 2;
  localparam logic [63:0] KPI_33 = (PI_60 * 64'd33 + 64'd2) >> 2;
  localparam logic [63:0] KPI_40 = (PI_60 * 64'd40 + 64'd2) >> 2;

  localparam logic signed [63:0] LOBE_LO = 64'd0 - KPI_6;
  localparam logic signed [63:0] LOBE_HI = KPI_20;

  // central meridians and half widths, west to east
  localparam logic [2:0][63:0] LOBE_CEN = {KPI_40, KPI_7, 64'd0 - KPI_33};
  localparam logic [2:0][63:0] LOBE_HW  = {KPI_20, KPI_13, KPI_27};

  localparam logic [64:0] RND_OUT = (SHIFT_IN > 0) ? (65'd1 << (SHIFT_IN - 1)) : 65'd0;

  typedef struct packed {
    logic              cmd;
    logic signed [31:0] horiz_in;
    logic signed [31:0] vert_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] horiz_out;
    logic signed [31:0] vert_out;
    logic              valid_res;
  } out_t;

  typedef struct packed {
    logic              ok;
    logic              cmd;
    logic [1:0]        lobe;
    logic signed [63:0] hs;
    logic [31:0]       vert;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [63:0] a;
  } front_t;

endpackage

[rtl/interrupted_sinusoidal_projection.sv]
// ---------------------------------------------------------------------------
// interrupted_sinusoidal_projection
// three-lobe interrupted sinusoidal projection, forward and inverse, Q3.28
// ---------------------------------------------------------------------------
// throughput: one request per cycle while the result side does not stall, set by the fully pipelined cosine
//   (eleven horner steps of five stages) and the 63-stage restoring divider
// reset clears queue pointers and pipeline valid bits only
// a stall on the result side freezes the back pipeline, the front keeps filling
module interrupted_sinusoidal_projection (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  isp_pkg::in_t  item,
  output logic          empty,
  input  logic          pop,
  output isp_pkg::out_t result
);
  // front: domain checks and forward lobe choice
  isp_pkg::front_t cls;
  isp_pkg::front_t mid_q;
  logic            mid_wr;
  logic            mid_rd;
  logic            mid_full;
  logic            mid_empty;

  isp_front u_front (
    .item (item),
    .cls  (cls)
  );

  assign mid_wr = push && !mid_full;
  assign full   = mid_full;

  // decoupling queue between front and back
  isp_fifo #(.W($bits(isp_pkg::front_t)), .DEPTH(4)) u_mid (
    .clk, .rst,
    .wr    (mid_wr),
    .wdata (cls),
    .rd    (mid_rd),
    .rdata (mid_q),
    .full  (mid_full),
    .empty (mid_empty)
  );

  // back: cosine, lobe test, division, rounding
  logic          bk_vld;
  isp_pkg::out_t bk_data;
  logic          out_full;
  logic          out_wr;
  logic          out_rd;

  isp_back u_back (
    .clk, .rst,
    .in_vld   (!mid_empty),
    .in_data  (mid_q),
    .take     (mid_rd),
    .out_vld  (bk_vld),
    .out_data (bk_data),
    .out_full (out_full)
  );

  // result queue: a finished result waits here while the pipeline moves on
  assign out_wr = bk_vld && !out_full;
  assign out_rd = pop && !empty;

  isp_fifo #(.W($bits(isp_pkg::out_t)), .DEPTH(2)) u_out (
    .clk, .rst,
    .wr    (out_wr),
    .wdata (bk_data),
    .rd    (out_rd),
    .rdata (result),
    .full  (out_full),
    .empty (empty)
  );

`ifndef SYNTH
  // back pipeline only takes from a non-empty queue
  a_mid_rd: assert property (@(posedge clk) disable iff (rst)
    mid_rd |-> !mid_empty)
    else $error("back took from empty queue");

  // a finished result never lands in a full result queue
  a_out_wr: assert property (@(posedge clk) disable iff (rst)
    out_wr |-> !out_full)
    else $error("result queue overflow");

  // a stalled result keeps the back pipeline frozen
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (bk_vld && out_full) |=> bk_vld)
    else $error("stalled result lost");

  // invalid results carry zeros
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.valid_res) |-> (result.horiz_out == 32'd0 && result.vert_out == 32'd0))
    else $error("invalid result not zeroed");

  // nothing waits right after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not empty after reset");
`endif

endmodule

[rtl/isp_fifo.sv]
// ---------------------------------------------------------------------------
// isp_fifo
// small register queue with full and empty flags
// ---------------------------------------------------------------------------
module isp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;

  assign full  = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (wr && !rd) begin
        cnt <= cnt + 1'b1;
      end else if (rd && !wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

endmodule

[rtl/isp_mul.sv]
// ---------------------------------------------------------------------------
// isp_mul
// two-stage multiplier from 32x32 partial products, shift of result, rounded when RND is set
// ---------------------------------------------------------------------------
module isp_mul #(
  parameter int A_W = 64,
  parameter int B_W = 64,
  parameter int O_W = 64,
  parameter int SH  = 60,
  parameter int RND = 1,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  input  logic [SW-1:0]  side_in,
  output logic [O_W-1:0] p,
  output logic [SW-1:0]  side_out
);
  localparam int NA = (A_W + 31) / 32;
  localparam int NB = (B_W + 31) / 32;
  localparam int PW = 32 * (NA + NB);

  logic [NA*32-1:0] ax;
  logic [NB*32-1:0] bx;
  logic [63:0]      pp [NA][NB];
  logic [SW-1:0]    side1;
  logic [PW-1:0]    acc;

  assign ax = (NA*32)'(a);
  assign bx = (NB*32)'(b);

  // sum of partial products plus half an output lsb when rounding
  always_comb begin
    acc = PW'(RND) << (SH - 1);
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(pp[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= {32'b0, ax[32*i +: 32]} * {32'b0, bx[32*j +: 32]};
        end
      end
      side1    <= side_in;
      p        <= acc[SH +: O_W];
      side_out <= side1;
    end
  end

endmodule

[rtl/isp_front.sv]
// ---------------------------------------------------------------------------
// isp_front
// widens the request to Q.60, checks the domain and picks the forward lobe
// ---------------------------------------------------------------------------
module isp_front (
  input  isp_pkg::in_t    item,
  output isp_pkg::front_t cls
);
  logic        hneg;
  logic        vneg;
  logic [31:0] hmag;
  logic [31:0] vmag;
  logic        ok_h;
  logic        ok_v;
  logic [63:0] a;
  logic [63:0] b;
  logic signed [63:0] hs;
  logic        ok;
  logic [1:0]  lobe;

  always_comb begin
    hneg = item.horiz_in[31];
    vneg = item.vert_in[31];
    hmag = hneg ? 32'(-item.horiz_in) : item.horiz_in;
    vmag = vneg ? 32'(-item.vert_in) : item.vert_in;
    ok_h = ((64'(hmag) >> isp_pkg::LIM_SH) == 64'd0);
    ok_v = ((64'(vmag) >> isp_pkg::LIM_SH) == 64'd0);
    b    = 64'(hmag) << isp_pkg::SHIFT_IN;
    a    = 64'(vmag) << isp_pkg::SHIFT_IN;
    hs   = hneg ? -$signed(b) : $signed(b);

    if (item.cmd == isp_pkg::CMD_FWD) begin
      ok = ok_h && ok_v && (a <= isp_pkg::HALF_PI) && (b <= isp_pkg::PI_Q60);
    end else begin
      ok = ok_h && ok_v && (a < isp_pkg::HALF_PI);
    end

    if (hs < isp_pkg::LOBE_LO) begin
      lobe = isp_pkg::LOBE_W;
    end else if (hs < isp_pkg::LOBE_HI) begin
      lobe = isp_pkg::LOBE_C;
    end else begin
      lobe = isp_pkg::LOBE_E;
    end

    cls.tag.ok   = ok;
    cls.tag.cmd  = item.cmd;
    cls.tag.lobe = lobe;
    cls.tag.hs   = hs;
    cls.tag.vert = item.vert_in;
    cls.a        = ok ? a : 64'd0;
  end

endmodule

[rtl/isp_back.sv]
// ---------------------------------------------------------------------------
// isp_back
// pipelined cosine, lobe test, restoring divider and output rounding
// ---------------------------------------------------------------------------
module isp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  isp_pkg::front_t in_data,
  output logic            take,
  output logic            out_vld,
  output isp_pkg::out_t   out_data,
  input  logic            out_full
);
  localparam int NS    = isp_pkg::NSTEP;
  localparam int QW    = 63;
  localparam int LAT   = 2 + NS * 5 + 1 + 2 + 1 + QW + 2;

  typedef struct packed {
    isp_pkg::tag_t tag;
    logic [63:0]   t;
  } cs_t;

  typedef struct packed {
    isp_pkg::tag_t   tag;
    logic [2:0]      neg;
    logic [2:0][63:0] m;
    logic [63:0]     c;
  } ls_t;

  typedef struct packed {
    logic        ok;
    logic        cmd;
    logic        neg;
    logic [63:0] cen;
    logic [63:0] resf;
    logic [31:0] vert;
    logic [1:0]  nlo;
  } dv_t;

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en      = !(out_vld && out_full);
  assign take    = en && in_vld;
  assign out_vld = vld_q[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], take};
    end
  end

  // square of the latitude magnitude
  logic [63:0]   t0;
  isp_pkg::tag_t tag_sq;

  isp_mul #(.SW($bits(isp_pkg::tag_t))) u_sq (
    .clk, .en, .a(in_data.a), .b(in_data.a), .side_in(in_data.tag),
    .p(t0), .side_out(tag_sq)
  );

  // horner steps of the cosine series
  cs_t         cs_c [0:NS];
  logic [63:0] r_c  [0:NS];

  assign cs_c[0] = '{tag: tag_sq, t: t0};
  assign r_c[0]  = isp_pkg::ONE_Q60;

  for (genvar s = 0; s < NS; s++) begin : g_step
    localparam int N = NS - s;
    localparam int D = (2 * N) * (2 * N - 1);
    localparam logic [70:0] RECIP = 71'(((136'd1 << 71) + 136'(D) - 136'd1) / 136'(D));

    logic [63:0] pr;
    logic [63:0] qt;
    logic [63:0] r_q;
    cs_t         sd1;
    cs_t         sd2;
    cs_t         sd3;

    isp_mul #(.SW($bits(cs_t))) u_tr (
      .clk, .en, .a(cs_c[s].t), .b(r_c[s]), .side_in(cs_c[s]),
      .p(pr), .side_out(sd1)
    );

    // exact floor division by the series constant
    isp_mul #(.B_W(71), .SH(71), .RND(0), .SW($bits(cs_t))) u_rc (
      .clk, .en, .a(pr), .b(RECIP), .side_in(sd1), .p(qt), .side_out(sd2)
    );

    always_ff @(posedge clk) begin
      if (en) begin
        r_q <= (qt >= isp_pkg::ONE_Q60) ? 64'd0 : isp_pkg::ONE_Q60 - qt;
        sd3 <= sd2;
      end
    end

    assign r_c[s+1]  = r_q;
    assign cs_c[s+1] = sd3;
  end

  // offsets from each central meridian
  logic [2:0]       dneg;
  logic [2:0][63:0] dmag;
  logic signed [63:0] dd;
  ls_t              ls;
  logic [63:0]      mf;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dd      = cs_c[NS].tag.hs - $signed(isp_pkg::LOBE_CEN[k]);
      dneg[k] = dd[63];
      dmag[k] = dd[63] ? 64'(-dd) : 64'(dd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ls <= '{tag: cs_c[NS].tag, neg: dneg, m: dmag, c: r_c[NS]};
      mf <= dmag[cs_c[NS].tag.lobe];
    end
  end

  // forward product and the three lobe limits
  logic [63:0]      fp;
  ls_t              ls2;
  logic [2:0][63:0] lim;

  isp_mul #(.SW($bits(ls_t))) u_fw (
    .clk, .en, .a(mf), .b(ls.c), .side_in(ls), .p(fp), .side_out(ls2)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lim
    isp_mul u_lim (
      .clk, .en, .a(isp_pkg::LOBE_HW[k]), .b(ls.c), .side_in(1'b0),
      .p(lim[k]), .side_out()
    );
  end

  // first lobe that holds x, forward result
  logic [2:0]  hit;
  logic [1:0]  sel;
  logic        inv_ok;
  logic [63:0] fsg;
  dv_t         dv_n;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hit[k] = (ls2.m[k] <= lim[k]);
    end
    if (hit[0]) begin
      sel = isp_pkg::LOBE_W;
    end else if (hit[1]) begin
      sel = isp_pkg::LOBE_C;
    end else begin
      sel = isp_pkg::LOBE_E;
    end
    inv_ok = ls2.tag.ok && (ls2.c >= isp_pkg::COS_EPS) && (hit != 3'b000);
    fsg    = ls2.neg[ls2.tag.lobe] ? -fp : fp;

    dv_n.ok   = (ls2.tag.cmd == isp_pkg::CMD_INV) ? inv_ok : ls2.tag.ok;
    dv_n.cmd  = ls2.tag.cmd;
    dv_n.neg  = ls2.neg[sel];
    dv_n.cen  = isp_pkg::LOBE_CEN[sel];
    dv_n.resf = fsg + isp_pkg::LOBE_CEN[ls2.tag.lobe];
    dv_n.vert = ls2.tag.vert;
    dv_n.nlo  = ls2.m[sel][1:0];
  end

  // restoring divider, one quotient bit per stage
  logic [63:0] dr_c [0:QW];
  logic [QW-1:0] dq_c [0:QW];
  logic [63:0] dd_c [0:QW];
  dv_t         dv_c [0:QW];
  logic [63:0] dr0;
  logic [63:0] dd0;
  dv_t         dv0;

  always_ff @(posedge clk) begin
    if (en) begin
      dr0 <= ls2.m[sel] >> 2;
      dd0 <= ls2.c;
      dv0 <= dv_n;
    end
  end

  assign dr_c[0] = dr0;
  assign dq_c[0] = '0;
  assign dd_c[0] = dd0;
  assign dv_c[0] = dv0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    localparam int B = QW - 1 - i;

    logic          nb;
    logic [63:0]   rs;
    logic          ge;
    logic [63:0]   r_q;
    logic [QW-1:0] q_q;
    logic [63:0]   d_q;
    dv_t           v_q;

    if (B == QW - 1) begin : g_b1
      assign nb = dv_c[i].nlo[1];
    end else if (B == QW - 2) begin : g_b0
      assign nb = dv_c[i].nlo[0];
    end else begin : g_bz
      assign nb = 1'b0;
    end

    assign rs = {dr_c[i][62:0], nb};
    assign ge = (rs >= dd_c[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        r_q <= ge ? rs - dd_c[i] : rs;
        q_q <= {dq_c[i][QW-2:0], ge};
        d_q <= dd_c[i];
        v_q <= dv_c[i];
      end
    end

    assign dr_c[i+1] = r_q;
    assign dq_c[i+1] = q_q;
    assign dd_c[i+1] = d_q;
    assign dv_c[i+1] = v_q;
  end

  // signed result in Q.60
  logic [63:0] qr;
  logic [63:0] res_n;
  logic [63:0] res;
  logic        res_ok;
  logic [31:0] res_vert;

  always_comb begin
    qr    = 64'((65'(dq_c[QW]) + 65'd1) >> 1);
    res_n = (dv_c[QW].cmd == isp_pkg::CMD_INV)
          ? ((dv_c[QW].neg ? -qr : qr) + dv_c[QW].cen)
          : dv_c[QW].resf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res      <= res_n;
      res_ok   <= dv_c[QW].ok;
      res_vert <= dv_c[QW].vert;
    end
  end

  // round to the output format and saturate
  logic          oneg;
  logic [63:0]   omag;
  logic [64:0]   orm;
  logic [31:0]   ohz;
  isp_pkg::out_t out_n;

  always_comb begin
    oneg = res[63];
    omag = oneg ? -res : res;
    orm  = (65'(omag) + isp_pkg::RND_OUT) >> isp_pkg::SHIFT_IN;
    if (oneg) begin
      ohz = (orm > 65'h0_8000_0000) ? 32'h8000_0000 : -orm[31:0];
    end else begin
      ohz = (orm > 65'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : orm[31:0];
    end
    out_n.horiz_out = res_ok ? ohz : 32'd0;
    out_n.vert_out  = res_ok ? res_vert : 32'd0;
    out_n.valid_res = res_ok;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_n;
    end
  end

endmodule
